@@ hdl/rdx_pkg.sv @@
// Shared types and constants for the decimal LSD radix sorter.
// Used by rdx_bcd, rdx_store and the top level; no dependencies.
package rdx_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VAL_W         = 31;
    localparam int DIGITS        = 10;
    localparam int DIG_W         = 4;
    localparam int DIGI_W        = $clog2(DIGITS);
    localparam int BCD_W         = DIGITS * DIG_W;
    localparam int BIN_W         = 32;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [BCD_W-1:0] bcd;
    } t_word;

    typedef struct packed {
        logic we;
        logic wsel;
        logic rsel;
    } t_mem_ctl;

endpackage

@@ hdl/decimal_lsd_radix_sort_top.sv @@
// Decimal LSD radix sorter. Each item holds busy through its BCD conversion; the next item is taken once busy drops.
// Sort: one pass per digit of the batch maximum over the n stored items, each pass a bucket
// offset scan over the ten digit values followed by one memory read and write per item.
// Output: n results on consecutive cycles, one per cycle; the receiver cannot stall.
// Reset is synchronous and clears control state; the item memories are not cleared.
// Depends on rdx_pkg, rdx_bcd, rdx_store.
module decimal_lsd_radix_sort_top #(
    parameter int MAX_ITEMS = rdx_pkg::MAX_ITEMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rdx_pkg::VAL_W-1:0] i_in_value,
    input  logic                      i_in_last,
    output logic                      o_valid,
    output logic [rdx_pkg::VAL_W-1:0] o_sorted_value,
    output logic                      o_out_last,
    output logic                      o_dropped
);
    import rdx_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0]     CNT_MAX  = CW'(MAX_ITEMS);
    localparam logic [DIGI_W-1:0] DIG_LAST = DIGI_W'(DIGITS - 1);
    localparam logic [DIGI_W-1:0] DIG_CNT  = DIGI_W'(DIGITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SORT = 3'd2;
    localparam logic [2:0] S_PREF = 3'd3;
    localparam logic [2:0] S_DIST = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    function automatic logic [DIG_W-1:0] digit_at(input logic [BCD_W-1:0] bcd,
                                                  input logic [DIGI_W-1:0] idx);
        logic [DIG_W-1:0] d;
        d = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (idx == DIGI_W'(k)) begin
                d = bcd[k*DIG_W +: DIG_W];
            end
        end
        return d;
    endfunction

    function automatic logic [DIGI_W-1:0] num_digits(input logic [BCD_W-1:0] bcd);
        logic [DIGI_W-1:0] n;
        n = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (bcd[k*DIG_W +: DIG_W] != '0) begin
                n = DIGI_W'(k + 1);
            end
        end
        return n;
    endfunction

    logic [2:0]        r_state;
    logic [CW-1:0]     r_items;
    logic [VAL_W-1:0]  r_max_val;
    logic [BCD_W-1:0]  r_max_bcd;
    logic              r_ovf;
    logic              r_last;
    logic [VAL_W-1:0]  r_in_val;
    logic [CW-1:0]     r_cnt   [DIGITS];
    logic [CW-1:0]     r_start [DIGITS];
    logic [CW-1:0]     r_acc;
    logic [DIGI_W-1:0] r_dig;
    logic [DIGI_W-1:0] r_pass;
    logic [DIGI_W-1:0] r_npass;
    logic [CW-1:0]     r_idx;
    logic              r_sel;
    logic              r_rd_v;
    logic              r_o_vld;
    logic              r_o_last;
    logic              r_o_drop;

    logic              accept;
    logic              conv_go;
    logic              conv_done;
    logic [BCD_W-1:0]  conv_bcd;
    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    t_word             mem_wdata;
    t_word             mem_rdata;
    logic [DIG_W-1:0]  rd_dig;
    logic [DIGI_W-1:0] nx_pass;
    logic              nx_ok;
    logic [DIG_W-1:0]  nx_dig;
    logic [CW-1:0]     idx_inc;
    logic [DIGI_W-1:0] max_digits;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign conv_go    = accept && (r_items < CNT_MAX);
    assign rd_dig     = digit_at(mem_rdata.bcd, r_pass);
    assign nx_pass    = r_pass + 1'b1;
    assign nx_ok      = (nx_pass < DIG_CNT);
    assign nx_dig     = digit_at(mem_rdata.bcd, nx_pass);
    assign idx_inc    = r_idx + 1'b1;
    assign max_digits = num_digits(r_max_bcd);

    rdx_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (conv_go),
        .i_value (i_in_value),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    // source memory is r_sel; a pass writes the other one
    always_comb begin
        mem_ctl       = '0;
        mem_ctl.rsel  = r_sel;
        mem_waddr     = r_items[AW-1:0];
        mem_wdata.val = r_in_val;
        mem_wdata.bcd = conv_bcd;
        mem_raddr     = r_idx[AW-1:0];
        if (r_state == S_CONV && conv_done) begin
            mem_ctl.we   = 1'b1;
            mem_ctl.wsel = r_sel;
        end else if (r_state == S_DIST && r_rd_v) begin
            mem_ctl.we   = 1'b1;
            mem_ctl.wsel = !r_sel;
            mem_waddr    = r_start[rd_dig][AW-1:0];
            mem_wdata    = mem_rdata;
        end
    end

    rdx_store #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_items   <= '0;
            r_max_val <= '0;
            r_max_bcd <= '0;
            r_ovf     <= 1'b0;
            r_last    <= 1'b0;
            r_cnt     <= '{default: '0};
            r_acc     <= '0;
            r_dig     <= '0;
            r_pass    <= '0;
            r_npass   <= '0;
            r_idx     <= '0;
            r_sel     <= 1'b0;
            r_rd_v    <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            r_o_vld <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last   <= i_in_last;
                        r_in_val <= i_in_value;
                        if (conv_go) begin
                            r_state <= S_CONV;
                        end else begin
                            r_ovf <= 1'b1;
                            if (i_in_last) begin
                                r_state <= S_SORT;
                            end
                        end
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        r_items <= r_items + 1'b1;
                        r_cnt[conv_bcd[DIG_W-1:0]] <= r_cnt[conv_bcd[DIG_W-1:0]] + 1'b1;
                        if (r_in_val > r_max_val) begin
                            r_max_val <= r_in_val;
                            r_max_bcd <= conv_bcd;
                        end
                        r_state <= r_last ? S_SORT : S_IDLE;
                    end
                end
                S_SORT: begin
                    r_npass <= max_digits;
                    r_pass  <= '0;
                    r_dig   <= '0;
                    r_acc   <= '0;
                    r_idx   <= '0;
                    r_rd_v  <= 1'b0;
                    if (max_digits == '0) begin
                        r_cnt   <= '{default: '0};
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PREF;
                    end
                end
                S_PREF: begin
                    r_start[r_dig] <= r_acc;
                    r_acc          <= r_acc + r_cnt[r_dig];
                    r_cnt[r_dig]   <= '0;
                    r_dig          <= r_dig + 1'b1;
                    if (r_dig == DIG_LAST) begin
                        r_idx   <= '0;
                        r_rd_v  <= 1'b0;
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    if (r_idx != r_items) begin
                        r_idx  <= idx_inc;
                        r_rd_v <= 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_rd_v) begin
                        r_start[rd_dig] <= r_start[rd_dig] + 1'b1;
                        // counts for the next digit ride along
                        if (nx_ok) begin
                            r_cnt[nx_dig] <= r_cnt[nx_dig] + 1'b1;
                        end
                    end
                    if (r_idx == r_items && !r_rd_v) begin
                        r_sel  <= !r_sel;
                        r_pass <= nx_pass;
                        r_dig  <= '0;
                        r_acc  <= '0;
                        r_idx  <= '0;
                        if (nx_pass == r_npass) begin
                            r_cnt   <= '{default: '0};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_PREF;
                        end
                    end
                end
                S_OUT: begin
                    r_idx    <= idx_inc;
                    r_o_last <= (idx_inc == r_items);
                    r_o_drop <= r_ovf;
                    if (idx_inc == r_items) begin
                        r_items   <= '0;
                        r_max_val <= '0;
                        r_max_bcd <= '0;
                        r_ovf     <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_o_vld;
    assign o_sorted_value = mem_rdata.val;
    assign o_out_last     = r_o_last;
    assign o_dropped      = r_o_drop;

endmodule

@@ hdl/rdx_bcd.sv @@
// Binary to BCD converter, shift-add-3, four bits per cycle.
// Depends on rdx_pkg.
module rdx_bcd (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [rdx_pkg::VAL_W-1:0] i_value,
    output logic                      o_done,
    output logic [rdx_pkg::BCD_W-1:0] o_bcd
);
    import rdx_pkg::*;

    localparam int                   STEP_W    = $clog2(CONV_STEPS);
    localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(CONV_STEPS - 1);
    localparam logic [DIG_W-1:0]     DAB_LIM   = 4'd5;
    localparam logic [DIG_W-1:0]     DAB_ADJ   = 4'd3;

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [BIN_W-1:0]  r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BIN_W-1:0]  n_bin;
    logic [BCD_W-1:0]  n_bcd;

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (n_bcd[d*DIG_W +: DIG_W] >= DAB_LIM) begin
                    n_bcd[d*DIG_W +: DIG_W] = n_bcd[d*DIG_W +: DIG_W] + DAB_ADJ;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[BIN_W-1]};
            n_bin = {n_bin[BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_go && r_run && (r_step == STEP_LAST);
            if (i_go) begin
                r_bin  <= {{(BIN_W - VAL_W){1'b0}}, i_value};
                r_bcd  <= '0;
                r_step <= '0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_bin  <= n_bin;
                r_bcd  <= n_bcd;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    r_run  <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

@@ hdl/rdx_store.sv @@
// Two item memories used ping-pong between digit passes, registered reads.
// Depends on rdx_pkg.
module rdx_store #(
    parameter int MAX_ITEMS = rdx_pkg::MAX_ITEMS_DEF
) (
    input  logic                         i_clk,
    input  rdx_pkg::t_mem_ctl            i_ctl,
    input  logic [$clog2(MAX_ITEMS)-1:0] i_waddr,
    input  rdx_pkg::t_word               i_wdata,
    input  logic [$clog2(MAX_ITEMS)-1:0] i_raddr,
    output rdx_pkg::t_word               o_rdata
);
    import rdx_pkg::*;

    t_word r_mem_a [MAX_ITEMS];
    t_word r_mem_b [MAX_ITEMS];
    t_word r_rd_a;
    t_word r_rd_b;
    logic  r_rsel;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we && !i_ctl.wsel) begin
            r_mem_a[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem_a[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we && i_ctl.wsel) begin
            r_mem_b[i_waddr] <= i_wdata;
        end
        r_rd_b <= r_mem_b[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_rsel <= i_ctl.rsel;
    end

    assign o_rdata = r_rsel ? r_rd_b : r_rd_a;

endmodule

@@ hdl/rdx_chk.sv @@
// Port-level checks for decimal_lsd_radix_sort_top, bound to the top level.
// Depends on rdx_pkg.
module rdx_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [rdx_pkg::VAL_W-1:0] i_in_value,
    input logic                      i_in_last,
    input logic                      o_valid,
    input logic [rdx_pkg::VAL_W-1:0] o_sorted_value,
    input logic                      o_out_last,
    input logic                      o_dropped
);
    import rdx_pkg::*;

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_last) |=> o_valid)
        else $error("result burst broken before last");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_last) |=> !o_valid)
        else $error("result right after last of batch");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_last) |=> (o_dropped == $past(o_dropped)))
        else $error("dropped flag changed inside a batch");

    a_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in_last) |=> busy)
        else $error("last transfer did not start sorting");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("outputs active after reset");

endmodule

bind decimal_lsd_radix_sort_top rdx_chk u_rdx_chk (.*);
